FILE: hdl/sbfa_pkg.sv
package sbfa_pkg;

  // Default sizes of the allocator.
  localparam int SECTORS_DEF    = 64;
  localparam int FILE_SLOTS_DEF = 16;

  // Field widths on the stream ports.
  localparam int REQ_W      = 2;
  localparam int NAME_W     = 16;
  localparam int WANT_W     = 7;
  localparam int STATUS_W   = 3;
  localparam int SECTOR_W   = 6;
  localparam int FREE_W     = 7;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  typedef logic [REQ_W-1:0]    req_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Request kinds.
  localparam req_t REQ_CREATE = 2'd0;
  localparam req_t REQ_DELETE = 2'd1;
  localparam req_t REQ_QUERY  = 2'd2;
  localparam req_t REQ_RSVD   = 2'd3;

  // Result status codes.
  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_NAME_USED = 3'd1;
  localparam status_t ST_NO_SPACE  = 3'd2;
  localparam status_t ST_NO_SLOT   = 3'd3;
  localparam status_t ST_NOT_FOUND = 3'd4;

endpackage

FILE: hdl/sector_bitmap_file_allocator.sv
// Sector file allocator. Keeps up to FILE_SLOTS named files and an owner map
// of SECTORS sectors. Create takes the first free slot and the lowest free
// sectors; delete frees a file's sectors and its slot; query lists a file's
// sectors in ascending order, one word each, the last word marked by tlast.
// Every other request gives a single word. After reset the owner map is
// cleared in a pass during which no request is taken. A request is then
// accepted, its name is searched slot by slot through one shared name
// comparator and the outcome is decided; a request that passes scans the
// owner map (one map read per cycle through the single owner comparator,
// held while the output side stalls), and the final word is handed over.
// A reserved request goes straight to its final word.
// Create and delete words carry has_sector 0; free_sectors always reports
// the count after the request.
module sector_bitmap_file_allocator #(
  parameter int SECTORS    = sbfa_pkg::SECTORS_DEF,
  parameter int FILE_SLOTS = sbfa_pkg::FILE_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // file_name [15:0], sector_count [22:16], zero [23]
  input  logic [sbfa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // req_type [1:0]
  input  logic [sbfa_pkg::REQ_W-1:0]      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // status [2:0], sector [8:3], free_sectors [15:9]
  output logic [sbfa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // has_sector [0]
  output logic                            m_axis_tuser,
  output logic                            m_axis_tlast
);

  localparam int SEC_W  = $clog2(SECTORS);
  localparam int CNT_W  = $clog2(SECTORS + 1);
  localparam int SLOT_W = (FILE_SLOTS > 1) ? $clog2(FILE_SLOTS) : 1;
  localparam int OWN_W  = $clog2(FILE_SLOTS + 1);
  localparam int WANT_W = sbfa_pkg::WANT_W;
  localparam int SECT_W = sbfa_pkg::SECTOR_W;
  localparam int FREE_W = sbfa_pkg::FREE_W;
  localparam int NAME_W = sbfa_pkg::NAME_W;

  localparam logic [SEC_W-1:0]  SEC_LAST  = SEC_W'(SECTORS - 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(FILE_SLOTS - 1);

  // Sequencer states.
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SLOT   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_SEC    = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]              state;
  sbfa_pkg::req_t          req;
  logic [NAME_W-1:0]       name;
  logic [WANT_W-1:0]       want;
  logic [SLOT_W-1:0]       slot_idx;
  logic                    found;
  logic [SLOT_W-1:0]       found_slot;
  logic                    free_ok;
  logic [SLOT_W-1:0]       free_slot;
  logic [SLOT_W-1:0]       cur_slot;
  logic [SEC_W-1:0]        idx;
  logic [CNT_W-1:0]        taken;
  logic [CNT_W-1:0]        free_count;
  sbfa_pkg::status_t       st;
  logic                    pend_valid;
  logic [SEC_W-1:0]        pend_sector;

  logic [FILE_SLOTS-1:0]   slot_valid;
  logic [NAME_W-1:0]       slot_name [FILE_SLOTS];
  logic [OWN_W-1:0]        owner_mem [SECTORS];
  logic [OWN_W-1:0]        rdata;

  // Output register.
  logic                    o_valid;
  sbfa_pkg::status_t       o_status;
  logic [SECT_W-1:0]       o_sector;
  logic                    o_has;
  logic [FREE_W-1:0]       o_free;
  logic                    o_last;

  logic                    out_free;
  logic                    o_load;
  logic [OWN_W-1:0]        code;
  logic [OWN_W-1:0]        cmp_val;
  logic                    hit;
  logic                    name_hit;
  logic                    create_done;
  logic                    q_push;
  logic                    sec_stall;
  logic                    sec_go;
  logic                    sec_last;
  logic                    start_scan;
  sbfa_pkg::status_t       dec_status;
  logic [SLOT_W-1:0]       scan_slot;
  logic                    wr_en;
  logic [OWN_W-1:0]        wr_data;
  logic                    rd_en;
  logic [SEC_W-1:0]        rd_addr;

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = {o_free, o_sector, o_status};
  assign m_axis_tuser  = o_has;
  assign m_axis_tlast  = o_last;
  assign out_free      = !o_valid || m_axis_tready;

  // A new word enters the output register for a listed sector or a final word.
  assign o_load = (q_push && out_free) || ((state == S_DONE) && out_free);

  // Shared comparators: one on slot names, one on the owner map word.
  assign code     = OWN_W'(cur_slot) + OWN_W'(1);
  assign cmp_val  = (req == sbfa_pkg::REQ_CREATE) ? '0 : code;
  assign hit      = (rdata == cmp_val);
  assign name_hit = slot_valid[slot_idx] && (slot_name[slot_idx] == name);

  // Owner map scan control.
  always_comb begin
    create_done = (state == S_SEC) && (req == sbfa_pkg::REQ_CREATE) &&
                  (WANT_W'(taken) == want);
    q_push      = (state == S_SEC) && (req == sbfa_pkg::REQ_QUERY) && hit && pend_valid;
    sec_stall   = q_push && !out_free;
    sec_go      = (state == S_SEC) && !create_done && !sec_stall;
    sec_last    = (idx == SEC_LAST);
  end

  // Outcome of the name search, checked in priority order: name in use, then space, then a free slot.
  always_comb begin
    start_scan = 1'b0;
    dec_status = sbfa_pkg::ST_OK;
    scan_slot  = found_slot;
    if (req == sbfa_pkg::REQ_CREATE) begin
      scan_slot = free_slot;
      priority if (found) begin
        dec_status = sbfa_pkg::ST_NAME_USED;
      end else if (want > WANT_W'(free_count)) begin
        dec_status = sbfa_pkg::ST_NO_SPACE;
      end else if (!free_ok) begin
        dec_status = sbfa_pkg::ST_NO_SLOT;
      end else begin
        start_scan = 1'b1;
      end
    end else if (!found) begin
      dec_status = sbfa_pkg::ST_NOT_FOUND;
    end else begin
      start_scan = 1'b1;
    end
  end

  // Owner map port: write at the current sector, read one ahead.
  always_comb begin
    wr_en   = (state == S_CLEAR) || (sec_go && hit && (req != sbfa_pkg::REQ_QUERY));
    wr_data = ((state == S_CLEAR) || (req == sbfa_pkg::REQ_DELETE)) ? '0 : code;
    rd_en   = ((state == S_DECIDE) && start_scan) || (sec_go && !sec_last);
    rd_addr = (state == S_DECIDE) ? '0 : idx + SEC_W'(1);
  end

  // Owner map memory.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      owner_mem[idx] <= wr_data;
    end
    if (rd_en) begin
      rdata <= owner_mem[rd_addr];
    end
  end

  // Slot name store, written when a create takes a slot.
  always_ff @(posedge clk) begin
    if ((state == S_DECIDE) && start_scan && (req == sbfa_pkg::REQ_CREATE)) begin
      slot_name[scan_slot] <= name;
    end
  end

  // Output word payload.
  always_ff @(posedge clk) begin
    if (q_push && out_free) begin
      o_status <= sbfa_pkg::ST_OK;
      o_sector <= SECT_W'(pend_sector);
      o_has    <= 1'b1;
      o_free   <= FREE_W'(free_count);
      o_last   <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      o_status <= st;
      o_sector <= pend_valid ? SECT_W'(pend_sector) : '0;
      o_has    <= pend_valid;
      o_free   <= FREE_W'(free_count);
      o_last   <= 1'b1;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      idx        <= '0;
      slot_valid <= '0;
      free_count <= CNT_W'(SECTORS);
      o_valid    <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (o_load) begin
        o_valid <= 1'b1;
      end else if (m_axis_tready) begin
        o_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          idx <= idx + SEC_W'(1);
          if (sec_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            req        <= s_axis_tuser;
            name       <= s_axis_tdata[NAME_W-1:0];
            want       <= s_axis_tdata[NAME_W +: WANT_W];
            slot_idx   <= '0;
            found      <= 1'b0;
            free_ok    <= 1'b0;
            pend_valid <= 1'b0;
            st         <= sbfa_pkg::ST_OK;
            if (s_axis_tuser == sbfa_pkg::REQ_RSVD) begin
              state <= S_DONE;
            end else begin
              state <= S_SLOT;
            end
          end
        end
        S_SLOT: begin
          if (name_hit && !found) begin
            found      <= 1'b1;
            found_slot <= slot_idx;
          end
          if (!slot_valid[slot_idx] && !free_ok) begin
            free_ok   <= 1'b1;
            free_slot <= slot_idx;
          end
          if (slot_idx == SLOT_LAST) begin
            state <= S_DECIDE;
          end else begin
            slot_idx <= slot_idx + SLOT_W'(1);
          end
        end
        S_DECIDE: begin
          if (start_scan) begin
            cur_slot <= scan_slot;
            idx      <= '0;
            taken    <= '0;
            if (req == sbfa_pkg::REQ_CREATE) begin
              slot_valid[scan_slot] <= 1'b1;
            end
            state <= S_SEC;
          end else begin
            st    <= dec_status;
            state <= S_DONE;
          end
        end
        S_SEC: begin
          if (create_done) begin
            state <= S_DONE;
          end else if (!sec_stall) begin
            if (hit) begin
              unique case (req)
                sbfa_pkg::REQ_CREATE: begin
                  taken      <= taken + CNT_W'(1);
                  free_count <= free_count - CNT_W'(1);
                end
                sbfa_pkg::REQ_DELETE: begin
                  free_count <= free_count + CNT_W'(1);
                end
                default: begin
                  pend_valid  <= 1'b1;
                  pend_sector <= idx;
                end
              endcase
            end
            if (sec_last) begin
              if (req == sbfa_pkg::REQ_DELETE) begin
                slot_valid[cur_slot] <= 1'b0;
              end
              state <= S_DONE;
            end else begin
              idx <= idx + SEC_W'(1);
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hdl/sbfa_check.sv
module sbfa_check #(
  parameter int SECTORS = sbfa_pkg::SECTORS_DEF
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [sbfa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tuser,
  input logic                            m_axis_tlast
);

  // A stalled word holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // Only defined status codes appear.
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[2:0] == sbfa_pkg::ST_OK ||
                       m_axis_tdata[2:0] == sbfa_pkg::ST_NAME_USED ||
                       m_axis_tdata[2:0] == sbfa_pkg::ST_NO_SPACE ||
                       m_axis_tdata[2:0] == sbfa_pkg::ST_NO_SLOT ||
                       m_axis_tdata[2:0] == sbfa_pkg::ST_NOT_FOUND))
    else $error("undefined status code");

  // A listed sector only comes with a successful query.
  a_has_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[2:0] == sbfa_pkg::ST_OK)
    else $error("sector listed with a failing status");

  // Only query listings span several words, and each carries a sector.
  a_mid_has: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser)
    else $error("non-final word without a sector");

  // The free count never exceeds the disk size.
  a_free: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[15:9] <= sbfa_pkg::FREE_W'(SECTORS))
    else $error("free count above sector total");

endmodule

bind sector_bitmap_file_allocator sbfa_check #(
  .SECTORS(SECTORS)
) u_sbfa_check (
  .clk          (clk),
  .rst          (rst),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);
